[rtl/nvme_feature_register_file_macros.svh]
// Assertion macros used by the feature register file top level.
// Depends on nothing; included by nvme_feature_register_file, the only module with assertions.
`ifndef NVME_FEATURE_REGISTER_FILE_MACROS_SVH
`define NVME_FEATURE_REGISTER_FILE_MACROS_SVH

// check cons in the same cycle whenever ante holds
`define NVFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nvfr assertion failed");

// check cons in the cycle after ante holds
`define NVFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nvfr assertion failed");

`endif

[rtl/nvfr_pkg.sv]
// Package for the feature register file: feature ids, status codes, widths.
// Also holds the vector table write port type. Depends on nothing.
`default_nettype none

package nvfr_pkg;

    localparam int QUEUE_LIMIT = 64;
    localparam int VEC_DEPTH   = QUEUE_LIMIT + 1;
    localparam int VEC_AW      = $clog2(VEC_DEPTH);
    localparam int VEC_W       = 17;
    localparam int NS_W        = 11;
    localparam int Q_W         = 16;
    localparam int TEMP_W      = 16;

    localparam logic [31:0] FID_ARB       = 32'h01;
    localparam logic [31:0] FID_POWER     = 32'h02;
    localparam logic [31:0] FID_LBA_RANGE = 32'h03;
    localparam logic [31:0] FID_TEMP      = 32'h04;
    localparam logic [31:0] FID_ERR_REC   = 32'h05;
    localparam logic [31:0] FID_WCACHE    = 32'h06;
    localparam logic [31:0] FID_QUEUES    = 32'h07;
    localparam logic [31:0] FID_COALESCE  = 32'h08;
    localparam logic [31:0] FID_VECTOR    = 32'h09;
    localparam logic [31:0] FID_ATOMIC    = 32'h0A;
    localparam logic [31:0] FID_ASYNC     = 32'h0B;
    localparam logic [31:0] FID_PROGRESS  = 32'h80;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_FIELD = 2'd1;
    localparam logic [1:0] ST_BAD_NS    = 2'd2;

    typedef struct packed {
        logic              en;
        logic [VEC_AW-1:0] addr;
        logic [VEC_W-1:0]  data;
    } vec_wr_t;

endpackage

`default_nettype wire

[rtl/nvfr_vector_mem.sv]
// Interrupt vector configuration table: one write port, one registered read port.
// Entries read as zero until written; a same-edge write to the read address is forwarded.
// Depends on nvfr_pkg.
`default_nettype none

module nvfr_vector_mem (
    input  wire                      clk,
    input  wire                      rst_n,
    input  nvfr_pkg::vec_wr_t        wr,
    input  wire [nvfr_pkg::VEC_AW-1:0] rd_addr,
    output logic [nvfr_pkg::VEC_W-1:0] rd_data
);
    import nvfr_pkg::*;

    logic [VEC_W-1:0]     mem [VEC_DEPTH];
    logic [VEC_DEPTH-1:0] valid_reg;
    logic [VEC_W-1:0]     rd_raw_reg;
    logic [VEC_W-1:0]     byp_data_reg;
    logic                 rd_hit_reg;
    logic                 rd_byp_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_raw_reg   <= mem[rd_addr];
        byp_data_reg <= wr.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
            rd_byp_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_hit_reg <= valid_reg[rd_addr];
            rd_byp_reg <= wr.en && (wr.addr == rd_addr);
        end
    end

    assign rd_data = rd_byp_reg ? byp_data_reg :
                     (rd_hit_reg ? rd_raw_reg : '0);

endmodule

`default_nettype wire

[rtl/nvme_feature_register_file.sv]
// Set/Get Features register file: top level, decode and feature state.
// Depends on nvfr_pkg, nvfr_vector_mem and the assertion macro header.
//
// One command word is taken on every cycle that start is high; busy never rises.
// Each command is registered on the accept edge, then decoded and applied to
// the feature state on the next edge, where its result is also registered and
// shown with done for exactly one cycle; one word is taken per cycle. The
// result cannot be held off, so a receiver must take it in the cycle done is
// high. The interrupt vector table is a registered memory read on the accept
// edge, with a write made on that same edge forwarded to the read. Write
// namespace_count through cfg_we/cfg_wdata only while no command is in flight.
`default_nettype none
`include "nvme_feature_register_file_macros.svh"

module nvme_feature_register_file (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [10:0] cfg_wdata,
    input  wire         start,
    output logic        busy,
    input  wire         mode,
    input  wire  [31:0] feature_word,
    input  wire  [31:0] feature_value,
    input  wire  [31:0] namespace_id,
    input  wire  [15:0] current_temperature,
    input  wire         smart_event_masked,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] result_dword,
    output logic        result_written,
    output logic        raise_temp_event
);
    import nvfr_pkg::*;

    logic              accept;
    logic              s1_valid_reg;
    logic              s1_set_reg;
    logic [31:0]       s1_fword_reg;
    logic [31:0]       s1_val_reg;
    logic [31:0]       s1_nsid_reg;
    logic [TEMP_W-1:0] s1_temp_reg;
    logic              s1_masked_reg;

    logic [NS_W-1:0]   ns_count_reg;
    logic [31:0]       arb_reg, arb_next;
    logic [31:0]       power_reg, power_next;
    logic [31:0]       thr_reg, thr_next;
    logic [31:0]       err_rec_reg, err_rec_next;
    logic [31:0]       wcache_reg, wcache_next;
    logic [31:0]       coalesce_reg, coalesce_next;
    logic [31:0]       atomic_reg, atomic_next;
    logic [31:0]       async_reg, async_next;
    logic [31:0]       progress_reg, progress_next;
    logic [Q_W-1:0]    granted_reg, granted_next;
    logic              warned_reg, warned_next;

    logic              done_reg;
    logic [1:0]        status_reg, status_next;
    logic [31:0]       result_reg, result_next;
    logic              written_reg, written_next;
    logic              raise_reg, raise_next;

    logic              hit;
    logic [31:0]       cur;
    logic [Q_W-1:0]    vec_idx;
    logic [Q_W-1:0]    rd_idx;
    logic [VEC_AW-1:0] rd_addr;
    logic [VEC_W-1:0]  vec_rd_data;
    vec_wr_t           vec_wr;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign rd_idx  = feature_value[Q_W-1:0];
    assign rd_addr = (rd_idx <= Q_W'(QUEUE_LIMIT)) ? rd_idx[VEC_AW-1:0] : '0;

    nvfr_vector_mem u_vec_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (vec_wr),
        .rd_addr (rd_addr),
        .rd_data (vec_rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_set_reg    <= mode;
            s1_fword_reg  <= feature_word;
            s1_val_reg    <= feature_value;
            s1_nsid_reg   <= namespace_id;
            s1_temp_reg   <= current_temperature;
            s1_masked_reg <= smart_event_masked;
        end
        status_reg  <= status_next;
        result_reg  <= result_next;
        written_reg <= written_next;
        raise_reg   <= raise_next;
    end

    assign vec_idx = s1_val_reg[Q_W-1:0];

    always_comb
    begin
        status_next   = ST_OK;
        result_next   = '0;
        written_next  = 1'b0;
        raise_next    = 1'b0;
        hit           = 1'b0;
        cur           = '0;
        arb_next      = arb_reg;
        power_next    = power_reg;
        thr_next      = thr_reg;
        err_rec_next  = err_rec_reg;
        wcache_next   = wcache_reg;
        coalesce_next = coalesce_reg;
        atomic_next   = atomic_reg;
        async_next    = async_reg;
        progress_next = progress_reg;
        granted_next  = granted_reg;
        warned_next   = warned_reg;
        vec_wr.en     = 1'b0;
        vec_wr.addr   = vec_idx[VEC_AW-1:0];
        vec_wr.data   = s1_val_reg[VEC_W-1:0];

        if (s1_valid_reg)
        begin
            case (s1_fword_reg)
                FID_ARB:
                begin
                    hit = 1'b1;
                    cur = arb_reg;
                    if (s1_set_reg) arb_next = s1_val_reg;
                end
                FID_POWER:
                begin
                    hit = 1'b1;
                    cur = power_reg;
                    if (s1_set_reg) power_next = s1_val_reg;
                end
                FID_ERR_REC:
                begin
                    hit = 1'b1;
                    cur = err_rec_reg;
                    if (s1_set_reg) err_rec_next = s1_val_reg;
                end
                FID_WCACHE:
                begin
                    hit = 1'b1;
                    cur = wcache_reg;
                    if (s1_set_reg) wcache_next = s1_val_reg;
                end
                FID_COALESCE:
                begin
                    hit = 1'b1;
                    cur = coalesce_reg;
                    if (s1_set_reg) coalesce_next = s1_val_reg;
                end
                FID_ATOMIC:
                begin
                    hit = 1'b1;
                    cur = atomic_reg;
                    if (s1_set_reg) atomic_next = s1_val_reg;
                end
                FID_ASYNC:
                begin
                    hit = 1'b1;
                    cur = async_reg;
                    if (s1_set_reg) async_next = s1_val_reg;
                end
                FID_PROGRESS:
                begin
                    hit = 1'b1;
                    cur = progress_reg;
                    if (s1_set_reg) progress_next = s1_val_reg;
                end
                FID_TEMP:
                begin
                    hit = 1'b1;
                    cur = thr_reg;
                    if (s1_set_reg)
                    begin
                        thr_next = s1_val_reg;
                        if ((s1_val_reg <= 32'(s1_temp_reg)) && !warned_reg)
                        begin
                            warned_next = 1'b1;
                            raise_next  = 1'b1;
                        end
                        else if ((s1_val_reg > 32'(s1_temp_reg)) && !s1_masked_reg)
                        begin
                            warned_next = 1'b0;
                        end
                    end
                end
                FID_LBA_RANGE:
                begin
                    if ((s1_nsid_reg == '0) || (s1_nsid_reg > 32'(ns_count_reg)))
                    begin
                        status_next = ST_BAD_NS;
                    end
                end
                FID_QUEUES:
                begin
                    if (s1_set_reg && (s1_val_reg != '0)
                        && (s1_val_reg <= 32'(QUEUE_LIMIT)))
                    begin
                        granted_next = s1_val_reg[Q_W-1:0];
                    end
                    result_next  = {granted_next, granted_next};
                    written_next = 1'b1;
                end
                FID_VECTOR:
                begin
                    if ((vec_idx > granted_reg) || (vec_idx > Q_W'(QUEUE_LIMIT)))
                    begin
                        status_next = ST_BAD_FIELD;
                    end
                    else if (s1_set_reg)
                    begin
                        vec_wr.en = 1'b1;
                    end
                    else
                    begin
                        result_next  = 32'(vec_rd_data);
                        written_next = 1'b1;
                    end
                end
                default:
                begin
                    status_next = ST_BAD_FIELD;
                end
            endcase

            if (hit && (!s1_set_reg || (s1_fword_reg == FID_ARB)))
            begin
                result_next  = cur;
                written_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            ns_count_reg <= NS_W'(1);
            arb_reg      <= '0;
            power_reg    <= '0;
            thr_reg      <= '0;
            err_rec_reg  <= '0;
            wcache_reg   <= '0;
            coalesce_reg <= '0;
            atomic_reg   <= '0;
            async_reg    <= '0;
            progress_reg <= '0;
            granted_reg  <= Q_W'(QUEUE_LIMIT);
            warned_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            done_reg     <= s1_valid_reg;
            if (cfg_we)
            begin
                ns_count_reg <= cfg_wdata;
            end
            arb_reg      <= arb_next;
            power_reg    <= power_next;
            thr_reg      <= thr_next;
            err_rec_reg  <= err_rec_next;
            wcache_reg   <= wcache_next;
            coalesce_reg <= coalesce_next;
            atomic_reg   <= atomic_next;
            async_reg    <= async_next;
            progress_reg <= progress_next;
            granted_reg  <= granted_next;
            warned_reg   <= warned_next;
        end
    end

    assign done             = done_reg;
    assign status           = status_reg;
    assign result_dword     = result_reg;
    assign result_written   = written_reg;
    assign raise_temp_event = raise_reg;

    `NVFR_ASSERT_NEXT(a_accept_to_stage, clk, rst_n, accept, s1_valid_reg)
    `NVFR_ASSERT_NEXT(a_stage_to_done, clk, rst_n, s1_valid_reg, done)
    `NVFR_ASSERT_IMP(a_error_clean, clk, rst_n, done && (status != ST_OK),
        (result_dword == '0) && !result_written && !raise_temp_event)
    `NVFR_ASSERT_IMP(a_raise_sets_warned, clk, rst_n, done && raise_temp_event,
        warned_reg && $past(!warned_reg))
    `NVFR_ASSERT_IMP(a_granted_range, clk, rst_n, 1'b1,
        (granted_reg != '0) && (granted_reg <= Q_W'(QUEUE_LIMIT)))

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking bench for the NVMe Set/Get Features register file.
// Depends on nvfr_pkg and nvme_feature_register_file; predicts each completion
// in a local model of the feature state and checks it against the done strobe.
module testbench;
    import nvfr_pkg::*;

    localparam logic MODE_GET     = 1'b0;
    localparam logic MODE_SET     = 1'b1;
    localparam int   CYCLE_LIMIT  = 200000;
    localparam int   DRAIN_CYCLES = 4;
    localparam int   PHASE_WORDS  = 290;

    typedef struct packed {
        logic        mode;
        logic [31:0] fid;
        logic [31:0] value;
        logic [31:0] nsid;
        logic [15:0] temp;
        logic        masked;
    } feature_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] dword;
        logic        written;
        logic        raise;
    } completion_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         cfg_we    = 1'b0;
    logic [10:0]  cfg_wdata = '0;
    logic         start     = 1'b0;
    feature_cmd_t on_bus    = '0;

    wire          busy;
    wire          done;
    wire [1:0]    status;
    wire [31:0]   result_dword;
    wire          result_written;
    wire          raise_temp_event;

    feature_cmd_t pending_cmds[$];
    completion_t  completion_q[$];
    completion_t  predicted;
    completion_t  oldest_completion;

    logic [31:0]      feature_store [0:8];
    logic [15:0]      granted_q;
    logic [VEC_W-1:0] vector_store [0:QUEUE_LIMIT];
    logic             temp_warned;
    logic [10:0]      ns_count;

    bit calm = 1'b0;
    int gap_left = 0;
    int cycle_count = 0;
    int failures = 0;
    int words_sent = 0;
    int results_checked = 0;
    int events_raised = 0;
    int settings_run = 1;

    nvme_feature_register_file i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .start               (start),
        .busy                (busy),
        .mode                (on_bus.mode),
        .feature_word        (on_bus.fid),
        .feature_value       (on_bus.value),
        .namespace_id        (on_bus.nsid),
        .current_temperature (on_bus.temp),
        .smart_event_masked  (on_bus.masked),
        .done                (done),
        .status              (status),
        .result_dword        (result_dword),
        .result_written      (result_written),
        .raise_temp_event    (raise_temp_event)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic completion_t apply_feature_command(feature_cmd_t c);
        completion_t r;
        int          slot;
        logic [15:0] idx;
        r    = '0;
        slot = -1;
        idx  = c.value[15:0];
        case (c.fid)
            FID_ARB:      slot = 0;
            FID_POWER:    slot = 1;
            FID_TEMP:     slot = 2;
            FID_ERR_REC:  slot = 3;
            FID_WCACHE:   slot = 4;
            FID_COALESCE: slot = 5;
            FID_ATOMIC:   slot = 6;
            FID_ASYNC:    slot = 7;
            FID_PROGRESS: slot = 8;
            FID_LBA_RANGE:
            begin
                if (c.nsid == 32'd0 || c.nsid > {21'd0, ns_count})
                    r.status = ST_BAD_NS;
            end
            FID_QUEUES:
            begin
                if (c.mode == MODE_SET && c.value >= 32'd1 && c.value <= QUEUE_LIMIT)
                    granted_q = c.value[15:0];
                r.dword   = {granted_q, granted_q};
                r.written = 1'b1;
            end
            FID_VECTOR:
            begin
                if (idx > granted_q || idx > QUEUE_LIMIT)
                    r.status = ST_BAD_FIELD;
                else if (c.mode == MODE_SET)
                    vector_store[idx] = c.value[VEC_W-1:0];
                else
                begin
                    r.dword   = 32'(vector_store[idx]);
                    r.written = 1'b1;
                end
            end
            default: r.status = ST_BAD_FIELD;
        endcase
        if (slot >= 0)
        begin
            if (c.mode == MODE_GET || c.fid == FID_ARB)
            begin
                r.dword   = feature_store[slot];
                r.written = 1'b1;
            end
            if (c.mode == MODE_SET)
            begin
                feature_store[slot] = c.value;
                if (c.fid == FID_TEMP)
                begin
                    if (c.value <= {16'd0, c.temp} && !temp_warned)
                    begin
                        temp_warned = 1'b1;
                        r.raise     = 1'b1;
                    end
                    else if (c.value > {16'd0, c.temp} && !c.masked)
                        temp_warned = 1'b0;
                end
            end
        end
        return r;
    endfunction

    function automatic feature_cmd_t random_feature_command();
        feature_cmd_t c;
        int           pick;
        c.mode   = 1'($urandom_range(0, 1));
        c.temp   = 16'($urandom);
        c.masked = 1'($urandom_range(0, 1));
        c.value  = $urandom;
        pick     = $urandom_range(0, 19);
        case (pick)
            0:       c.fid = FID_ARB;
            1:       c.fid = FID_POWER;
            2:       c.fid = FID_LBA_RANGE;
            3:       c.fid = FID_TEMP;
            4:       c.fid = FID_ERR_REC;
            5:       c.fid = FID_WCACHE;
            6:       c.fid = FID_QUEUES;
            7:       c.fid = FID_COALESCE;
            8:       c.fid = FID_VECTOR;
            9:       c.fid = FID_ATOMIC;
            10:      c.fid = FID_ASYNC;
            11:      c.fid = FID_PROGRESS;
            12:      c.fid = FID_QUEUES;
            13:      c.fid = FID_VECTOR;
            14:      c.fid = FID_TEMP;
            15:      c.fid = FID_LBA_RANGE;
            16, 17:  c.fid = $urandom_range(0, 255);
            default: c.fid = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0:       c.nsid = 32'd0;
            1:       c.nsid = {21'd0, ns_count};
            2:       c.nsid = {21'd0, ns_count} + 32'd1;
            3:       c.nsid = $urandom_range(0, ns_count + 2);
            default: c.nsid = $urandom;
        endcase
        if (c.fid == FID_QUEUES && $urandom_range(0, 3) != 0)
            c.value = $urandom_range(0, QUEUE_LIMIT + 2);
        if (c.fid == FID_VECTOR && $urandom_range(0, 3) != 0)
            c.value[15:0] = 16'($urandom_range(0, QUEUE_LIMIT + 2));
        if (c.fid == FID_TEMP && $urandom_range(0, 2) != 0)
            c.value = {16'd0, c.temp} + $urandom_range(0, 4) - 32'd2;
        return c;
    endfunction

    task automatic add_command(input logic m, input logic [31:0] fid, input logic [31:0] value,
                               input logic [31:0] nsid, input logic [15:0] temp,
                               input logic masked);
        feature_cmd_t c;
        c.mode   = m;
        c.fid    = fid;
        c.value  = value;
        c.nsid   = nsid;
        c.temp   = temp;
        c.masked = masked;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || completion_q.size() != 0 || start)
            @(negedge clk);
    endtask

    task automatic run_phase(input logic [10:0] ns, input int words, input bit no_idle);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= ns;
        ns_count   = ns;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_run++;
        calm = no_idle;
        repeat (words)
            pending_cmds.push_back(random_feature_command());
    endtask

    // driver: hold a word while busy, insert random idle bursts, advance on accept
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predicted = apply_feature_command(on_bus);
                completion_q.push_back(predicted);
                words_sent++;
                if (predicted.raise)
                    events_raised++;
            end
            if (!(start && busy))
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() != 0 && !calm && $urandom_range(0, 11) == 0)
                begin
                    gap_left = $urandom_range(0, 18);
                    start <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    on_bus <= pending_cmds.pop_front();
                    start  <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: compare each strobed completion with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (completion_q.size() == 0)
            begin
                $error("completion with no command outstanding");
                failures++;
            end
            else
            begin
                oldest_completion = completion_q.pop_front();
                results_checked++;
                if (status !== oldest_completion.status)
                begin
                    $error("status: expected %0d, got %0d", oldest_completion.status, status);
                    failures++;
                end
                if (result_dword !== oldest_completion.dword)
                begin
                    $error("result_dword: expected %h, got %h",
                           oldest_completion.dword, result_dword);
                    failures++;
                end
                if (result_written !== oldest_completion.written)
                begin
                    $error("result_written: expected %0d, got %0d",
                           oldest_completion.written, result_written);
                    failures++;
                end
                if (raise_temp_event !== oldest_completion.raise)
                begin
                    $error("raise_temp_event: expected %0d, got %0d",
                           oldest_completion.raise, raise_temp_event);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < 9; i++)
            feature_store[i] = '0;
        for (int i = 0; i <= QUEUE_LIMIT; i++)
            vector_store[i] = '0;
        granted_q   = 16'(QUEUE_LIMIT);
        temp_warned = 1'b0;
        ns_count    = 11'd1;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        add_command(MODE_GET, FID_ARB, 32'h0, 32'h1, 16'h0, 1'b0);
        add_command(MODE_SET, FID_ARB, 32'hFFFF_FFFF, 32'h1, 16'h0, 1'b0);
        add_command(MODE_SET, FID_ARB, 32'h0, 32'h1, 16'h0, 1'b0);
        add_command(MODE_GET, FID_QUEUES, 32'h0, 32'h0, 16'h0, 1'b0);
        add_command(MODE_SET, FID_QUEUES, 32'h0, 32'h0, 16'h0, 1'b0);
        add_command(MODE_SET, FID_QUEUES, 32'(QUEUE_LIMIT + 1), 32'h0, 16'h0, 1'b0);
        add_command(MODE_SET, FID_QUEUES, 32'h1, 32'h0, 16'h0, 1'b0);
        add_command(MODE_SET, FID_VECTOR, 32'hFFFF_0001, 32'h0, 16'h0, 1'b0);
        add_command(MODE_GET, FID_VECTOR, 32'h0000_0001, 32'h0, 16'h0, 1'b0);
        add_command(MODE_GET, FID_VECTOR, 32'h0000_0002, 32'h0, 16'h0, 1'b0);
        add_command(MODE_SET, FID_QUEUES, 32'(QUEUE_LIMIT), 32'h0, 16'h0, 1'b0);
        add_command(MODE_GET, FID_VECTOR, 32'(QUEUE_LIMIT), 32'h0, 16'h0, 1'b0);
        add_command(MODE_SET, FID_VECTOR, 32'(QUEUE_LIMIT + 1), 32'h0, 16'h0, 1'b0);
        add_command(MODE_SET, FID_VECTOR, 32'hFFFF_FFFF, 32'h0, 16'h0, 1'b0);
        add_command(MODE_GET, FID_LBA_RANGE, 32'h0, 32'h0, 16'h0, 1'b0);
        add_command(MODE_GET, FID_LBA_RANGE, 32'h0, 32'h1, 16'h0, 1'b0);
        add_command(MODE_SET, FID_LBA_RANGE, 32'h0, 32'h2, 16'h0, 1'b0);
        add_command(MODE_SET, FID_LBA_RANGE, 32'h0, 32'hFFFF_FFFF, 16'h0, 1'b0);
        add_command(MODE_SET, FID_TEMP, 32'd300, 32'h0, 16'd350, 1'b0);
        add_command(MODE_SET, FID_TEMP, 32'd300, 32'h0, 16'd350, 1'b0);
        add_command(MODE_SET, FID_TEMP, 32'd400, 32'h0, 16'd350, 1'b1);
        add_command(MODE_SET, FID_TEMP, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 1'b0);
        add_command(MODE_SET, FID_TEMP, 32'h0, 32'h0, 16'h0, 1'b1);
        add_command(MODE_SET, FID_PROGRESS, 32'hFFFF_FFFF, 32'h0, 16'h0, 1'b0);
        add_command(MODE_GET, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0);
        add_command(MODE_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);

        run_phase(11'd0, PHASE_WORDS, 1'b0);
        run_phase(11'd1024, PHASE_WORDS, 1'b0);
        run_phase(11'h7FF, PHASE_WORDS, 1'b0);
        run_phase(11'($urandom_range(2, 1023)), PHASE_WORDS, 1'b0);
        run_phase(11'd1, PHASE_WORDS, 1'b1);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d completions for %0d Set/Get Features words over %0d namespace counts",
                 results_checked, words_sent, settings_run);
        $display("%0d temperature events predicted", events_raised);
        if (failures == 0 && completion_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
